FILE: sv/axf_pkg.sv
package axf_pkg;

  localparam int unsigned OffsetBitsDef = 32;
  localparam int unsigned MaxAddsDef    = 3;

  localparam logic [31:0] AdrpMask    = 32'h9F00_0000;
  localparam logic [31:0] AdrpMatch   = 32'h9000_0000;
  localparam logic [31:0] ImmOpMask   = 32'h7F00_0000;
  localparam logic [31:0] AddImmMatch = 32'h1100_0000;
  localparam logic [31:0] SubImmMatch = 32'h5100_0000;
  localparam logic [31:0] PaciaspWord = 32'hD503_233F;

  localparam logic [4:0] RegX0 = 5'd0;
  localparam logic [4:0] RegSp = 5'd31;

  typedef struct packed {
    logic        adrp_x0;
    logic [31:0] adrp_page;
    logic        add_imm;
    logic        add_x0;
    logic [11:0] add_value;
    logic        sub_sp;
    logic        paciasp;
  } dec_t;

  typedef struct packed {
    logic        ref_found;
    logic [31:0] ref_offset;
    logic        head_found;
    logic [31:0] head_offset;
  } result_t;

endpackage

FILE: sv/axf_decode.sv
module axf_decode
  import axf_pkg::*;
(
  input  logic [31:0] word_i,
  output dec_t        dec_o
);

  logic [20:0] adrp_imm;

  assign adrp_imm = {word_i[23:5], word_i[30:29]};

  always_comb begin
    dec_o.adrp_x0   = ((word_i & AdrpMask) == AdrpMatch) && (word_i[4:0] == RegX0);
    // page immediate shifted up by 12, truncated to 32 bits
    dec_o.adrp_page = {adrp_imm[19:0], 12'h000};
    dec_o.add_imm   = (word_i & ImmOpMask) == AddImmMatch;
    dec_o.add_x0    = word_i[4:0] == RegX0;
    dec_o.add_value = word_i[21:10];
    dec_o.sub_sp    = ((word_i & ImmOpMask) == SubImmMatch) && (word_i[4:0] == RegSp);
    dec_o.paciasp   = word_i == PaciaspWord;
  end

endmodule

FILE: sv/axf_scan.sv
module axf_scan
  import axf_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef,
  parameter int unsigned MAX_ADDS    = MaxAddsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  dec_t        dec_i,
  input  logic        last_i,
  input  logic [31:0] target_i,
  output logic        emit_o,
  output result_t     res_o
);

  localparam int unsigned IdxW = OFFSET_BITS - 2;
  localparam int unsigned CntW = $clog2(MAX_ADDS + 1);

  logic [IdxW-1:0]        widx_q, widx_d;
  logic                   pvalid_q, pvalid_d;
  logic [31:0]            pvalue_q, pvalue_d;
  logic [CntW-1:0]        pcnt_q, pcnt_d;
  logic [31:0]            poff_q, poff_d;
  logic                   phead_v_q, phead_v_d;
  logic [31:0]            phead_q, phead_d;
  logic                   lhead_v_q, lhead_v_d;
  logic [31:0]            lhead_q, lhead_d;
  logic                   prev_pac_q, prev_pac_d;
  logic                   rep_q, rep_d;

  logic [OFFSET_BITS+31:0] ofs_ext;
  logic [31:0]             ofs;
  logic [CntW-1:0]         cnt_inc;
  logic                    close_win;
  logic                    hit;
  logic                    hit_end;
  logic                    found;

  assign ofs_ext = {32'h0, widx_q, 2'b00};
  assign ofs     = ofs_ext[31:0];
  assign cnt_inc = pcnt_q + CntW'(1);

  always_comb begin
    widx_d     = widx_q + IdxW'(1);
    pvalid_d   = pvalid_q;
    pvalue_d   = pvalue_q;
    pcnt_d     = pcnt_q;
    poff_d     = poff_q;
    phead_v_d  = phead_v_q;
    phead_d    = phead_q;
    lhead_v_d  = lhead_v_q;
    lhead_d    = lhead_q;
    prev_pac_d = dec_i.paciasp;
    rep_d      = rep_q;
    close_win  = 1'b0;

    // extend or close the open window
    if (pvalid_q) begin
      if (dec_i.add_imm) begin
        if (dec_i.add_x0) begin
          pvalue_d = pvalue_q + {20'h0, dec_i.add_value};
        end
        pcnt_d = cnt_inc;
        if (cnt_inc == CntW'(MAX_ADDS)) begin
          close_win = 1'b1;
        end
      end else begin
        close_win = 1'b1;
      end
    end

    hit = close_win && !rep_q && (pvalue_d == target_i);
    if (close_win) begin
      pvalid_d = 1'b0;
      pcnt_d   = '0;
    end
    if (hit) begin
      rep_d = 1'b1;
    end

    // open a new window on ADRP x0
    if (!rep_d && dec_i.adrp_x0) begin
      pvalue_d  = dec_i.adrp_page + {ofs[31:12], 12'h000};
      pvalid_d  = 1'b1;
      pcnt_d    = '0;
      poff_d    = ofs;
      phead_v_d = lhead_v_q;
      phead_d   = lhead_q;
    end

    if (dec_i.sub_sp && (widx_q != '0)) begin
      lhead_v_d = 1'b1;
      lhead_d   = prev_pac_q ? (ofs - 32'd4) : ofs;
    end

    // cut-off window evaluated at the end of the image
    hit_end = last_i && !hit && pvalid_d && !rep_d && (pvalue_d == target_i);
    found   = hit || hit_end;
    emit_o  = hit || (last_i && (hit_end || !rep_d));

    res_o.ref_found   = found;
    res_o.ref_offset  = found ? poff_d : 32'h0;
    res_o.head_found  = found && phead_v_d;
    res_o.head_offset = (found && phead_v_d) ? phead_d : 32'h0;

    if (last_i) begin
      widx_d     = '0;
      pvalid_d   = 1'b0;
      pvalue_d   = 32'h0;
      pcnt_d     = '0;
      poff_d     = 32'h0;
      phead_v_d  = 1'b0;
      phead_d    = 32'h0;
      lhead_v_d  = 1'b0;
      lhead_d    = 32'h0;
      prev_pac_d = 1'b0;
      rep_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q     <= '0;
      pvalid_q   <= 1'b0;
      pvalue_q   <= 32'h0;
      pcnt_q     <= '0;
      poff_q     <= 32'h0;
      phead_v_q  <= 1'b0;
      phead_q    <= 32'h0;
      lhead_v_q  <= 1'b0;
      lhead_q    <= 32'h0;
      prev_pac_q <= 1'b0;
      rep_q      <= 1'b0;
    end else if (step_i) begin
      widx_q     <= widx_d;
      pvalid_q   <= pvalid_d;
      pvalue_q   <= pvalue_d;
      pcnt_q     <= pcnt_d;
      poff_q     <= poff_d;
      phead_v_q  <= phead_v_d;
      phead_q    <= phead_d;
      lhead_v_q  <= lhead_v_d;
      lhead_q    <= lhead_d;
      prev_pac_q <= prev_pac_d;
      rep_q      <= rep_d;
    end
  end

`ifndef SYNTHESIS
  a_one_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q |-> !emit_o)
    else $error("second result after a reported match");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pvalid_q |-> (pcnt_q < CntW'(MAX_ADDS)))
    else $error("open window holds too many ADD words");

  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (!rep_q && !pvalid_q && !lhead_v_q && (widx_q == '0)))
    else $error("stream state not cleared after last word");
`endif

endmodule

FILE: sv/axf_result_reg.sv
module axf_result_reg
  import axf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // slot is free when empty or being taken this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: sv/arm64_string_xref_function_finder.sv
// Scans a stream of AArch64 instruction words from one code image (last_i on
// the final word) for the first ADRP x0 whose page value plus up to MAX_ADDS
// directly following ADD-immediate x0 words equals the configured string
// offset, and reports that word's byte offset together with the head of the
// enclosing function (the nearest earlier SUB-immediate to SP, moved back one
// word behind a PACIASP). At most one result word is given per image: on the
// word that closes the matching window, or a not-found word at the end of the
// image. The block takes one instruction word per clock cycle: each word
// passes an input register and then a decode and state update in the
// scan stage, whose running state is the only loop. A result is loaded
// into the output register when its instruction word retires from the
// input register, and out_valid_o rises with that load.
// The input side stalls only while a result is waiting in the output register
// and the word in the input register would produce another. Write
// target_offset only while no image is in flight.
module arm64_string_xref_function_finder
  import axf_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef,
  parameter int unsigned MAX_ADDS    = MaxAddsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // instruction words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_i,
  input  logic        last_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ref_found_o,
  output logic [31:0] ref_offset_o,
  output logic        head_found_o,
  output logic [31:0] head_offset_o,
  // target_offset register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_target_offset_i
);

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_word_q;
  logic        s1_last_q;
  logic [31:0] target_q;

  logic        in_take;
  logic        retire;
  logic        emit;
  logic        slot_free;
  dec_t        dec;
  result_t     res_scan;
  result_t     res_out;

  assign cfg_ready_o = !s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 32'h0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_target_offset_i;
    end
  end

  // retire the held word unless its result has nowhere to go
  assign retire     = s1_valid_q && (!emit || slot_free);
  assign in_stall_o = s1_valid_q && !retire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (retire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_word_q <= word_i;
      s1_last_q <= last_i;
    end
  end

  axf_decode u_decode (
    .word_i (s1_word_q),
    .dec_o  (dec)
  );

  axf_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .MAX_ADDS    (MAX_ADDS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (retire),
    .dec_i    (dec),
    .last_i   (s1_last_q),
    .target_i (target_q),
    .emit_o   (emit),
    .res_o    (res_scan)
  );

  axf_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (retire && emit),
    .res_i       (res_scan),
    .free_o      (slot_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign ref_found_o   = res_out.ref_found;
  assign ref_offset_o  = res_out.ref_offset;
  assign head_found_o  = res_out.head_found;
  assign head_offset_o = res_out.head_offset;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output slot can take a word");
`endif

endmodule

FILE: tb/sv/arm64_string_xref_function_finder_tb.sv
module arm64_string_xref_function_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import axf_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  // Slack for results still passing the input and output registers.
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } scan_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] word_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ref_found_o;
  logic [31:0] ref_offset_o;
  logic        head_found_o;
  logic [31:0] head_offset_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_target_offset_i = '0;

  arm64_string_xref_function_finder dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .word_i              (word_i),
    .last_i              (last_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .ref_found_o         (ref_found_o),
    .ref_offset_o        (ref_offset_o),
    .head_found_o        (head_found_o),
    .head_offset_o       (head_offset_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_target_offset_i (cfg_target_offset_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Words waiting for the driver, and the image being assembled.
  scan_item_t  word_queue[$];
  logic [31:0] img_words[$];
  // Results the scanner must produce, oldest first.
  result_t     expected_results[$];

  // Scanner model: target register plus per-image stream state.
  logic [31:0] target_cfg = '0;
  logic [29:0] scan_index = '0;
  bit          win_open = 1'b0;
  logic [31:0] win_value = '0;
  int          win_adds = 0;
  logic [31:0] win_ofs = '0;
  bit          win_head_known = 1'b0;
  logic [31:0] win_head_ofs = '0;
  bit          head_known = 1'b0;
  logic [31:0] head_ofs = '0;
  logic [31:0] prev_word = '0;
  bit          ref_reported = 1'b0;

  // Bookkeeping.
  int unsigned cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_seen = 0;
  int unsigned words_queued = 0;
  int unsigned images_sent = 0;
  int unsigned results_seen = 0;
  int unsigned refs_seen = 0;
  int unsigned cfg_writes = 0;

  // Handshake state shared between the posedge monitor and negedge drivers.
  bit          word_taken = 1'b0;
  int          in_gap = 0;
  int          stall_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  scan_item_t  next_item;
  result_t     want;

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------

  // Close the open window; queue a found result if it hits and none was given.
  function automatic bit close_window();
    bit      hit;
    result_t r;
    hit = win_open && !ref_reported && (win_value == target_cfg);
    if (hit) begin
      r.ref_found   = 1'b1;
      r.ref_offset  = win_ofs;
      r.head_found  = win_head_known;
      r.head_offset = win_head_known ? win_head_ofs : 32'd0;
      expected_results.push_back(r);
      ref_reported = 1'b1;
    end
    win_open = 1'b0;
    win_adds = 0;
    return hit;
  endfunction

  // Advance the scanner by one accepted word and queue any result it yields.
  task automatic scan_word(input logic [31:0] w, input logic lst);
    logic [31:0] ofs;
    logic [20:0] page_imm;
    bit          emitted;
    ofs = {scan_index, 2'b00};
    emitted = 1'b0;

    // An open window swallows following ADD-immediates, counting x0 targets.
    if (win_open) begin
      if ((w & ImmOpMask) == AddImmMatch) begin
        if (w[4:0] == RegX0) win_value = win_value + 32'(w[21:10]);
        win_adds++;
        if (win_adds >= int'(MaxAddsDef)) emitted = close_window();
      end else begin
        emitted = close_window();
      end
    end

    // ADRP x0 opens a new window until a reference has been reported.
    if (!ref_reported && (w & AdrpMask) == AdrpMatch && w[4:0] == RegX0) begin
      page_imm       = {w[23:5], w[30:29]};
      win_value      = {page_imm[19:0], 12'h000} + {ofs[31:12], 12'h000};
      win_open       = 1'b1;
      win_adds       = 0;
      win_ofs        = ofs;
      win_head_known = head_known;
      win_head_ofs   = head_ofs;
    end

    // Track the latest function head: SUB SP at a nonzero offset, PACIASP-aware.
    if ((w & ImmOpMask) == SubImmMatch && w[4:0] == RegSp && scan_index != '0) begin
      head_known = 1'b1;
      head_ofs   = (prev_word == PaciaspWord) ? ofs - 32'd4 : ofs;
    end

    prev_word  = w;
    scan_index = scan_index + 30'd1;

    if (lst) begin
      // Evaluate a window cut off by the end of the image with what it has.
      if (!emitted && win_open) emitted = close_window();
      if (!emitted && !ref_reported) expected_results.push_back('0);
      scan_index     = '0;
      win_open       = 1'b0;
      win_value      = '0;
      win_adds       = 0;
      win_ofs        = '0;
      win_head_known = 1'b0;
      win_head_ofs   = '0;
      head_known     = 1'b0;
      head_ofs       = '0;
      prev_word      = '0;
      ref_reported   = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Instruction encoders and image assembly
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] enc_adrp(input logic [4:0] rd, input logic [20:0] imm);
    return {1'b1, imm[1:0], 5'b10000, imm[20:2], rd};
  endfunction

  // ADD/SUB immediate; sf, shift and source register are don't-cares here.
  function automatic logic [31:0] enc_imm_op(input logic [31:0] match, input logic [4:0] rd,
                                             input logic [11:0] imm12);
    return {1'($urandom), match[30:24], 2'($urandom), imm12, 5'($urandom), rd};
  endfunction

  // Mostly short gaps, a few long ones, and occasional runs with none at all.
  function automatic int pick_gap(inout bit calm);
    int r;
    if ($urandom_range(0, 63) == 0) calm = !calm;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Hand the assembled image to the driver, marking its final word.
  task automatic flush_image();
    foreach (img_words[i]) begin
      word_queue.push_back('{word: img_words[i], last: (i == img_words.size() - 1)});
    end
    words_queued += img_words.size();
    img_words.delete();
    images_sent++;
  endtask

  // Append ADRP x0 plus up to four ADDs aimed at the target, exact or one bit off.
  task automatic plant_reference(input logic [31:0] tgt, input bit exact);
    logic [31:0] ofs;
    logic [31:0] sum;
    logic [31:0] page;
    logic [20:0] page_imm;
    logic [11:0] add_val[4];
    logic [4:0]  add_rd[4];
    int          n;
    int          fix;
    ofs = 32'(img_words.size()) << 2;
    n   = $urandom_range(0, 4);
    sum = '0;
    fix = -1;
    for (int i = 0; i < n; i++) begin
      add_rd[i]  = ($urandom_range(0, 9) < 7) ? RegX0 : 5'($urandom_range(1, 31));
      add_val[i] = 12'($urandom);
    end
    // Only the first MaxAddsDef ADDs count; fix the last x0 one among them.
    for (int i = 0; i < n && i < int'(MaxAddsDef); i++) begin
      if (add_rd[i] == RegX0) fix = i;
    end
    for (int i = 0; i < n && i < int'(MaxAddsDef); i++) begin
      if (add_rd[i] == RegX0 && i != fix) sum = sum + 32'(add_val[i]);
    end
    if (fix >= 0) begin
      add_val[fix] = 12'(tgt - sum);
      sum = sum + 32'(add_val[fix]);
    end
    page     = tgt - sum - {ofs[31:12], 12'h000};
    page_imm = {1'($urandom), page[31:12]};
    if (!exact) page_imm[$urandom_range(0, 19)] ^= 1'b1;
    img_words.push_back(enc_adrp(RegX0, page_imm));
    for (int i = 0; i < n; i++) img_words.push_back(enc_imm_op(AddImmMatch, add_rd[i], add_val[i]));
  endtask

  // One random image: noise, prologues, planted and stray references.
  task automatic build_random_image(input logic [31:0] tgt);
    int len;
    int pick;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 30);
    while (img_words.size() < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        img_words.push_back($urandom);
      end else if (pick < 44) begin
        if ($urandom_range(0, 1) != 0) img_words.push_back(PaciaspWord);
        img_words.push_back(enc_imm_op(SubImmMatch,
                                       ($urandom_range(0, 7) == 0) ? 5'($urandom) : RegSp,
                                       12'($urandom)));
      end else if (pick < 50) begin
        img_words.push_back(PaciaspWord);
      end else if (pick < 70) begin
        plant_reference(tgt, $urandom_range(0, 3) != 0);
      end else if (pick < 80) begin
        img_words.push_back(enc_adrp(($urandom_range(0, 3) == 0) ? 5'($urandom) : RegX0,
                                     21'($urandom)));
      end else begin
        img_words.push_back(enc_imm_op(AddImmMatch,
                                       ($urandom_range(0, 1) != 0) ? RegX0 : 5'($urandom),
                                       12'($urandom)));
      end
    end
    flush_image();
  endtask

  // Write target_offset; the new value applies from the accepting edge on.
  task automatic write_target(input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_target_offset_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    target_cfg = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every word is taken and every result is in, then let the pipe drain.
  task automatic wait_idle();
    while (word_queue.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present words at the falling edge, hold each until it is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!in_valid_i || word_taken) begin
      if (in_gap > 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (word_queue.size() != 0) begin
        next_item   = word_queue.pop_front();
        in_valid_i <= 1'b1;
        word_i     <= next_item.word;
        last_i     <= next_item.last;
        in_gap     <= pick_gap(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result side in random runs.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left  <= pick_gap(out_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: advance the model on each taken word, check each result word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    word_taken = rst_ni && in_valid_i && !in_stall_o;
    if (word_taken) begin
      words_seen++;
      scan_word(word_i, last_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (ref_found_o) refs_seen++;
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("result word with none expected: found %0b ofs %h head %0b/%h",
                                ref_found_o, ref_offset_o, head_found_o, head_offset_o));
      end else begin
        want = expected_results.pop_front();
        if (ref_found_o !== want.ref_found)
          note_mismatch($sformatf("ref_found: expected %0b, got %0b",
                                  want.ref_found, ref_found_o));
        if (ref_offset_o !== want.ref_offset)
          note_mismatch($sformatf("ref_offset: expected %h, got %h",
                                  want.ref_offset, ref_offset_o));
        if (head_found_o !== want.head_found)
          note_mismatch($sformatf("head_found: expected %0b, got %0b",
                                  want.head_found, head_found_o));
        if (head_offset_o !== want.head_offset)
          note_mismatch($sformatf("head_offset: expected %h, got %h",
                                  want.head_offset, head_offset_o));
      end
    end
  end

  // Watchdog on a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("arm64_string_xref_function_finder: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] tgt;
    int unsigned phase_start;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed images against target 0x00401238.
    write_target(32'h0040_1238);

    // Extreme words; ADRP window opened and evaluated on the last word, no hit.
    img_words.push_back(32'h0000_0000);
    img_words.push_back(32'hFFFF_FFFF);
    img_words.push_back(enc_adrp(RegX0, 21'h1F_FFFF));
    flush_image();

    // Single-word image: nothing found.
    img_words.push_back(PaciaspWord);
    flush_image();

    // PACIASP moves the head back a word; window cut off by the last word hits.
    img_words.push_back(PaciaspWord);
    img_words.push_back(enc_imm_op(SubImmMatch, RegSp, 12'h040));
    img_words.push_back(enc_adrp(RegX0, 21'h401));
    img_words.push_back(enc_imm_op(AddImmMatch, RegX0, 12'h238));
    flush_image();

    // No head; non-x0 ADD consumed; third ADD closes a hit; later ADRP ignored.
    img_words.push_back(enc_adrp(RegX0, 21'h401));
    img_words.push_back(enc_imm_op(AddImmMatch, 5'd1, 12'h005));
    img_words.push_back(enc_imm_op(AddImmMatch, RegX0, 12'h200));
    img_words.push_back(enc_imm_op(AddImmMatch, RegX0, 12'h038));
    img_words.push_back(enc_adrp(RegX0, 21'h401));
    img_words.push_back(enc_imm_op(AddImmMatch, RegX0, 12'h238));
    flush_image();

    // SUB SP at offset zero and SUB to x5 are no heads; ADRP x1 ignored;
    // the window closes after three ADDs, so the fourth cannot complete it.
    img_words.push_back(enc_imm_op(SubImmMatch, RegSp, 12'h010));
    img_words.push_back(enc_imm_op(SubImmMatch, 5'd5, 12'h010));
    img_words.push_back(enc_imm_op(SubImmMatch, RegSp, 12'h020));
    img_words.push_back(enc_adrp(5'd1, 21'h401));
    img_words.push_back(enc_adrp(RegX0, 21'h401));
    img_words.push_back(enc_imm_op(AddImmMatch, 5'd1, 12'h000));
    img_words.push_back(enc_imm_op(AddImmMatch, 5'd2, 12'h000));
    img_words.push_back(enc_imm_op(AddImmMatch, 5'd3, 12'h000));
    img_words.push_back(enc_imm_op(AddImmMatch, RegX0, 12'h238));
    flush_image();

    // Plain head; a non-ADD word closes the hit; trailing SUB SP is the last word.
    img_words.push_back(32'h0000_0000);
    img_words.push_back(enc_imm_op(SubImmMatch, RegSp, 12'h030));
    img_words.push_back(enc_adrp(RegX0, 21'h401));
    img_words.push_back(enc_imm_op(AddImmMatch, RegX0, 12'h238));
    img_words.push_back(32'hFFFF_FFFF);
    img_words.push_back(enc_imm_op(SubImmMatch, RegSp, 12'h030));
    flush_image();

    wait_idle();

    // Random phases, each under its own target, extremes first.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       tgt = 32'h0000_0000;
        1:       tgt = 32'hFFFF_FFFF;
        2:       tgt = $urandom & 32'hFFFF_F000;
        default: tgt = $urandom;
      endcase
      write_target(tgt);
      phase_start = words_queued;
      while (words_queued - phase_start < 215) build_random_image(tgt);
      wait_idle();
    end

    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d result words never arrived", expected_results.size()));

    $display("%0d instruction words in %0d images under %0d target settings",
             words_seen, images_sent, cfg_writes);
    $display("%0d result words checked, %0d with a reference, %0d mismatches",
             results_seen, refs_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("arm64_string_xref_function_finder: match");
    end else begin
      $display("arm64_string_xref_function_finder: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/axf_pkg.sv
sv/axf_decode.sv
sv/axf_scan.sv
sv/axf_result_reg.sv
sv/arm64_string_xref_function_finder.sv
tb/sv/arm64_string_xref_function_finder_tb.sv
